// ===== hdl/rep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rep_pkg: shared types and constants of the ring exclusion sweep
// Field widths, operation and register codes, and the item and result records.
// ----------------------------------------------------------------------------
package rep_pkg;

  localparam int unsigned PROB_W     = 17;
  localparam int unsigned RAND_W     = 16;
  localparam int unsigned OCC_W      = 32;
  localparam int unsigned SITE_OUT_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [PROB_W-1:0] PROB_EMPTY_RST = 17'd32768;
  localparam logic [PROB_W-1:0] PROB_OCC_RST   = 17'd65536;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } rep_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROB_AFTER_EMPTY    = 1'b0,
    CFG_PROB_AFTER_OCCUPIED = 1'b1
  } rep_cfg_e;

  typedef struct packed {
    logic              opcode;
    logic [OCC_W-1:0]  load_occupancy;
    logic [RAND_W-1:0] random_value;
  } rep_item_t;

  typedef struct packed {
    logic [SITE_OUT_W-1:0] site_index;
    logic                  hopped;
    logic [OCC_W-1:0]      occupancy;
    logic                  sweep_last;
  } rep_result_t;

endpackage : rep_pkg
`default_nettype wire

// ===== hdl/rep_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rep_if: item channels of the ring exclusion sweep
// Valid/ready channels for step items and for result items.
// ----------------------------------------------------------------------------
interface rep_step_if import rep_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [OCC_W-1:0]  load_occupancy;
  logic [RAND_W-1:0] random_value;

  modport source (output valid, output opcode, output load_occupancy,
                  output random_value, input ready);
  modport sink   (input valid, input opcode, input load_occupancy,
                  input random_value, output ready);
endinterface : rep_step_if

interface rep_result_if import rep_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SITE_OUT_W-1:0] site_index;
  logic                  hopped;
  logic [OCC_W-1:0]      occupancy;
  logic                  sweep_last;

  modport source (output valid, output site_index, output hopped,
                  output occupancy, output sweep_last, input ready);
  modport sink   (input valid, input site_index, input hopped,
                  input occupancy, input sweep_last, output ready);
endinterface : rep_result_if
`default_nettype wire

// ===== hdl/rep_site_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rep_site_update: next-state logic for one item
// Applies a load or a single site update to the ring and sweep state.
// ----------------------------------------------------------------------------
module rep_site_update import rep_pkg::*; #(
  parameter int unsigned SITES = 32
) (
  input  rep_item_t                        item_i,
  input  logic [SITES-1:0]                 ring_i,
  input  logic [$clog2(SITES)-1:0]         next_site_i,
  input  logic [$clog2(SITES+1)-1:0]       remaining_i,
  input  logic                             prev_occ_i,
  input  logic [PROB_W-1:0]                prob_empty_i,
  input  logic [PROB_W-1:0]                prob_occ_i,
  output logic [SITES-1:0]                 ring_o,
  output logic [$clog2(SITES)-1:0]         next_site_o,
  output logic [$clog2(SITES+1)-1:0]       remaining_o,
  output logic                             prev_occ_o,
  output rep_result_t                      result_o
);

  localparam int unsigned SW = $clog2(SITES);
  localparam int unsigned CW = $clog2(SITES+1);

  logic [SW-1:0]     site, below;
  logic              site_full, below_full, hop;
  logic [PROB_W-1:0] thr;
  logic [CW-1:0]     rem_start, rem_after;
  logic [SITES-1:0]  ring_hop;

  always_comb begin
    site       = next_site_i;
    below      = (site == '0) ? SW'(SITES - 1) : site - SW'(1);
    site_full  = ring_i[site];
    below_full = ring_i[below];
    thr        = prev_occ_i ? prob_occ_i : prob_empty_i;
    hop        = site_full && !below_full && ({1'b0, item_i.random_value} < thr);

    // A fresh sweep skips one site when the site below its start is empty.
    if (remaining_i == '0) begin
      rem_start = below_full ? CW'(SITES) : CW'(SITES - 1);
    end else begin
      rem_start = remaining_i;
    end
    rem_after = rem_start - CW'(1);

    ring_hop = ring_i;
    if (hop) begin
      ring_hop[site]  = 1'b0;
      ring_hop[below] = 1'b1;
    end

    if (item_i.opcode == OP_UPDATE) begin
      ring_o      = ring_hop;
      next_site_o = (site == SW'(SITES - 1)) ? '0 : site + SW'(1);
      remaining_o = rem_after;
      prev_occ_o  = site_full;
    end else begin
      ring_o      = SITES'(item_i.load_occupancy);
      next_site_o = next_site_i;
      remaining_o = remaining_i;
      prev_occ_o  = prev_occ_i;
    end

    result_o.occupancy   = OCC_W'(ring_o);
    result_o.site_index  = (item_i.opcode == OP_UPDATE) ? SITE_OUT_W'(site) : '0;
    result_o.hopped      = (item_i.opcode == OP_UPDATE) && hop;
    result_o.sweep_last  = (item_i.opcode == OP_UPDATE) && (rem_after == '0);
  end

endmodule : rep_site_update
`default_nettype wire

// ===== hdl/ring_exclusion_process_sweep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_exclusion_process_sweep: sequential-update exclusion process on a ring
// Top level with item register, update logic, result register and the
// probability registers.
// ----------------------------------------------------------------------------
// The block returns exactly one result item for each item that it takes: the
// item is captured in an input register, the whole site update is worked out
// from it and lands in the result register together with the new ring state.
// The sustained rate is one item per cycle when the result side does not
// stall, set by the single update stage that reads and writes the ring state.
// A load item replaces the ring occupancy and leaves the sweep position alone;
// an update item visits the next site of the sweep and lets its particle hop
// to the site below when that site is empty and the random value is below the
// threshold chosen by whether the previously visited site was occupied. The
// user must write the two thresholds through the configuration port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ring_exclusion_process_sweep import rep_pkg::*; #(
  parameter int unsigned SITES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [PROB_W-1:0]     cfg_data_i,
  rep_step_if.sink              step_i,
  rep_result_if.source          result_o
);

  localparam int unsigned SW = $clog2(SITES);
  localparam int unsigned CW = $clog2(SITES+1);

  // Threshold registers.
  logic [PROB_W-1:0] prob_empty_q, prob_occ_q;

  // Ring and sweep state.
  logic [SITES-1:0] ring_q, ring_d;
  logic [SW-1:0]    next_site_q, next_site_d;
  logic [CW-1:0]    remaining_q, remaining_d;
  logic             prev_occ_q, prev_occ_d;

  // Input and result registers.
  logic        in_valid_q, out_valid_q;
  rep_item_t   item_q;
  rep_result_t res_q, res_d;
  logic        advance, step_fire;

  // The update stage fires whenever it holds an item and the result register
  // is empty or being emptied, so both stages stream at one item per cycle.
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign step_i.ready = !in_valid_q || advance;
  assign step_fire    = step_i.valid && step_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_empty_q <= PROB_EMPTY_RST;
      prob_occ_q   <= PROB_OCC_RST;
    end else if (cfg_we_i) begin
      unique case (rep_cfg_e'(cfg_idx_i))
        CFG_PROB_AFTER_EMPTY:    prob_empty_q <= cfg_data_i;
        CFG_PROB_AFTER_OCCUPIED: prob_occ_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (step_i.ready) begin
      in_valid_q <= step_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      item_q.opcode         <= step_i.opcode;
      item_q.load_occupancy <= step_i.load_occupancy;
      item_q.random_value   <= step_i.random_value;
    end
  end

  rep_site_update #(
    .SITES (SITES)
  ) u_update (
    .item_i       (item_q),
    .ring_i       (ring_q),
    .next_site_i  (next_site_q),
    .remaining_i  (remaining_q),
    .prev_occ_i   (prev_occ_q),
    .prob_empty_i (prob_empty_q),
    .prob_occ_i   (prob_occ_q),
    .ring_o       (ring_d),
    .next_site_o  (next_site_d),
    .remaining_o  (remaining_d),
    .prev_occ_o   (prev_occ_d),
    .result_o     (res_d)
  );

  // The state moves only when an item leaves the update stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q      <= '0;
      next_site_q <= '0;
      remaining_q <= '0;
      prev_occ_q  <= 1'b0;
    end else if (advance) begin
      ring_q      <= ring_d;
      next_site_q <= next_site_d;
      remaining_q <= remaining_d;
      prev_occ_q  <= prev_occ_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.site_index = res_q.site_index;
  assign result_o.hopped     = res_q.hopped;
  assign result_o.occupancy  = res_q.occupancy;
  assign result_o.sweep_last = res_q.sweep_last;

  // The sweep counter never exceeds the ring size and the position stays on it.
  a_state_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (remaining_q <= CW'(SITES)) && (next_site_q <= SW'(SITES - 1)))
    else $error("sweep state out of range");

  // An update only moves particles, it never creates or destroys one.
  a_particles_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (item_q.opcode == OP_UPDATE)) |->
      ($countones(ring_d) == $countones(ring_q)))
    else $error("particle count changed by an update");

  // A hop is reported exactly when the ring changes under an update.
  a_hop_matches_ring : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (item_q.opcode == OP_UPDATE)) |->
      (res_d.hopped == (ring_d != ring_q)))
    else $error("hop flag disagrees with ring update");

endmodule : ring_exclusion_process_sweep
`default_nettype wire

// ===== dv/ring_exclusion_process_sweep_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_exclusion_process_sweep_tb: self-checking bench of the ring sweep
// Drives load and update items with random idling on both channels, keeps its
// own copy of the ring and sweep state to work out every result item, and
// compares each result field by field. Thresholds are changed between phases.
// ----------------------------------------------------------------------------
module ring_exclusion_process_sweep_tb;
  import rep_pkg::*;

  localparam int unsigned SITES      = 32;
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PROB_W-1:0]    cfg_data_i;

  rep_step_if   step_ch ();
  rep_result_if result_ch ();

  ring_exclusion_process_sweep #(
    .SITES (SITES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step_ch),
    .result_o   (result_ch)
  );

  // The bench's own view of the block: ring occupancy, sweep position, the
  // number of sites still to visit in this sweep and whether the site visited
  // last held a particle. The sweep origin itself is never visible at the
  // outputs, so it is not kept.
  logic [SITES-1:0]  ring_occ;
  int unsigned       visit_site;
  int unsigned       sites_left;
  bit                prev_full;
  logic [PROB_W-1:0] thr_after_empty;
  logic [PROB_W-1:0] thr_after_full;

  rep_result_t ring_results_due[$];
  int unsigned mismatch_count;

  // Idling controls shared between the test tasks and the result side.
  bit          src_gaps_on;
  bit          sink_stalls_on;
  int unsigned hold_off_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  // Works out the result of one accepted item and advances the ring state,
  // exactly one result per item.
  function automatic rep_result_t advance_ring(input rep_item_t it);
    rep_result_t       res;
    int unsigned       site;
    int unsigned       below;
    logic [PROB_W-1:0] thr;
    res = '0;
    if (it.opcode == OP_LOAD) begin
      // A load replaces the occupancy only; the sweep carries on as it was.
      ring_occ = SITES'(it.load_occupancy);
    end else begin
      visit_site = visit_site % SITES;
      if (sites_left == 0) begin
        // A new sweep opens here. It is one site shorter when the site just
        // below its start is empty at this moment.
        sites_left = SITES;
        below      = (visit_site == 0) ? SITES - 1 : visit_site - 1;
        if (!ring_occ[below]) sites_left--;
      end
      site  = visit_site;
      below = (site == 0) ? SITES - 1 : site - 1;
      if (ring_occ[site]) begin
        thr = prev_full ? thr_after_full : thr_after_empty;
        if (!ring_occ[below] && (PROB_W'(it.random_value) < thr)) begin
          ring_occ[site]  = 1'b0;
          ring_occ[below] = 1'b1;
          res.hopped      = 1'b1;
        end
        prev_full = 1'b1;
      end else begin
        prev_full = 1'b0;
      end
      visit_site = (site + 1) % SITES;
      sites_left--;
      res.site_index = SITE_OUT_W'(site);
      res.sweep_last = (sites_left == 0);
    end
    res.occupancy = OCC_W'(ring_occ);
    return res;
  endfunction

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Samples sitting right at a threshold are where an off-by-one in the
  // comparison would show, so they are favoured.
  function automatic logic [RAND_W-1:0] near_threshold(input logic [PROB_W-1:0] thr);
    logic [PROB_W-1:0] pick;
    if (thr == 0) return '0;
    if (thr > PROB_W'(16'hFFFF)) return '1;
    pick = thr - PROB_W'($urandom_range(0, 1));
    return RAND_W'(pick);
  endfunction

  function automatic logic [RAND_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return near_threshold(thr_after_empty);
      3:       return near_threshold(thr_after_full);
      default: return RAND_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Occupancy words of varied density, so that hops are sometimes free and
  // sometimes mostly blocked.
  function automatic logic [OCC_W-1:0] pick_occupancy();
    case ($urandom_range(0, 5))
      0:       return $urandom() & $urandom();
      1:       return $urandom() | $urandom();
      2:       return $urandom() & $urandom() & $urandom();
      3:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return $urandom();
    endcase
  endfunction

  // Offers one item and waits until the block takes it. Valid is left high
  // afterwards so that back-to-back items leave no gap in it.
  task automatic send_item(input rep_op_e op, input logic [OCC_W-1:0] occ,
                           input logic [RAND_W-1:0] sample);
    int unsigned gap;
    rep_item_t   it;
    gap = src_gaps_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      step_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.opcode         = op;
    it.load_occupancy = occ;
    it.random_value   = sample;
    step_ch.valid          <= 1'b1;
    step_ch.opcode         <= it.opcode;
    step_ch.load_occupancy <= it.load_occupancy;
    step_ch.random_value   <= it.random_value;
    do @(posedge clk_i); while (!step_ch.ready);
    ring_results_due.push_back(advance_ring(it));
  endtask

  // Update items carry noise in the unused occupancy field and load items
  // carry noise in the unused sample, so both are seen to be ignored.
  task automatic send_update(input logic [RAND_W-1:0] sample);
    send_item(OP_UPDATE, $urandom(), sample);
  endtask

  task automatic send_load(input logic [OCC_W-1:0] occ);
    send_item(OP_LOAD, occ, RAND_W'($urandom()));
  endtask

  // Stops offering items and waits until every result has come back. As each
  // item gives exactly one result, the block is idle once the list is empty.
  task automatic settle_idle();
    @(negedge clk_i);
    step_ch.valid <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input rep_cfg_e sel, input logic [PROB_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_PROB_AFTER_EMPTY) begin
      thr_after_empty = value;
    end else begin
      thr_after_full = value;
    end
  endtask

  task automatic set_thresholds(input logic [PROB_W-1:0] after_empty,
                                input logic [PROB_W-1:0] after_full);
    settle_idle();
    write_threshold(CFG_PROB_AFTER_EMPTY, after_empty);
    write_threshold(CFG_PROB_AFTER_OCCUPIED, after_full);
  endtask

  // Hand-picked items at the reset thresholds: an update on the empty ring
  // opens a sweep one site short, a full ring blocks every hop, a particle
  // with an empty site below hops at both ends of the sample range, and a
  // load lands in the middle of a running sweep.
  task automatic test_directed_cases();
    send_update(16'h0000);
    send_load(32'hFFFF_FFFF);
    send_update(16'h0000);
    send_update(16'hFFFF);
    send_load(32'h0000_0008);
    send_update(16'hFFFF);
    send_load(32'h0000_0030);
    send_update(16'h8000);
    send_update(16'h7FFF);
    send_load(32'hAAAA_AAAA);
    send_update(16'h7FFF);
    send_update(16'h8000);
    send_update(16'h0000);
    send_update(16'hFFFF);
    send_load(32'h5555_5555);
    send_update(16'h8000);
    send_update(16'h7FFF);
    send_update(16'hFFFF);
    send_load(32'h0000_0000);
    send_update(16'h0000);
    send_load(32'h8000_0001);
    send_update(16'h0000);
  endtask

  // Threshold settings at and around the extremes, including values above
  // 65536 which must always let a free particle hop, and zero which never
  // does. Each setting gets a fresh ring and a run of updates.
  task automatic test_threshold_extremes();
    logic [PROB_W-1:0] settings [8][2];
    settings = '{'{17'd0,      17'd0},      '{17'd65536,  17'd65536},
                 '{17'd131071, 17'd131071}, '{17'd0,      17'd131071},
                 '{17'd65535,  17'd1},      '{17'd1,      17'd65535},
                 '{17'd131071, 17'd0},      '{PROB_EMPTY_RST, PROB_OCC_RST}};
    foreach (settings[k]) begin
      set_thresholds(settings[k][0], settings[k][1]);
      send_load(pick_occupancy());
      repeat (28) send_update(pick_sample());
    end
  endtask

  // The result side holds off for a long stretch while items keep coming
  // back to back, so the block fills and must stall its input.
  task automatic test_backpressure();
    settle_idle();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    @(posedge clk_i);
    hold_off_cycles = 120;
    send_load(pick_occupancy());
    repeat (40) send_update(pick_sample());
    settle_idle();
  endtask

  // Phases of random traffic, each under its own thresholds and its own mix
  // of idling. Most items are updates, so sweeps run through many times;
  // occasional loads reshuffle the ring in the middle of a sweep.
  task automatic test_random_traffic();
    logic [PROB_W-1:0] after_empty;
    logic [PROB_W-1:0] after_full;
    for (int phase = 0; phase < 6; phase++) begin
      if ($urandom_range(0, 2) == 0) begin
        after_empty = ($urandom_range(0, 1) != 0) ? 17'd0 : 17'd131071;
      end else begin
        after_empty = PROB_W'($urandom_range(0, 131071));
      end
      after_full = ($urandom_range(0, 3) == 0) ? 17'd65536
                                               : PROB_W'($urandom_range(0, 131071));
      set_thresholds(after_empty, after_full);
      src_gaps_on    = (phase % 3) != 0;
      sink_stalls_on = (phase % 3) != 1;
      send_load(pick_occupancy());
      repeat (100) begin
        if ($urandom_range(0, 99) < 6) begin
          send_load(pick_occupancy());
        end else begin
          send_update(pick_sample());
        end
      end
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // Result side: ready is changed at the falling edge only. A requested
  // hold-off wins over the random stalls.
  initial begin : drive_result_ready
    int unsigned stall_left;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        result_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls_on && ($urandom_range(0, 99) < 20)) begin
        result_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result is matched against the oldest outstanding
  // expectation.
  always @(posedge clk_i) begin : check_results
    rep_result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (ring_results_due.size() == 0) begin
        $error("result item with nothing outstanding: site %0d occupancy %h",
               result_ch.site_index, result_ch.occupancy);
        mismatch_count++;
      end else begin
        want = ring_results_due.pop_front();
        if (result_ch.site_index !== want.site_index) begin
          $error("site_index: expected %0d, got %0d", want.site_index,
                 result_ch.site_index);
          mismatch_count++;
        end
        if (result_ch.hopped !== want.hopped) begin
          $error("hopped: expected %0b, got %0b", want.hopped, result_ch.hopped);
          mismatch_count++;
        end
        if (result_ch.occupancy !== want.occupancy) begin
          $error("occupancy: expected %h, got %h", want.occupancy,
                 result_ch.occupancy);
          mismatch_count++;
        end
        if (result_ch.sweep_last !== want.sweep_last) begin
          $error("sweep_last: expected %0b, got %0b", want.sweep_last,
                 result_ch.sweep_last);
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hang anywhere in the run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : run_tests
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_PROB_AFTER_EMPTY;
    cfg_data_i             = '0;
    step_ch.valid          = 1'b0;
    step_ch.opcode         = OP_LOAD;
    step_ch.load_occupancy = '0;
    step_ch.random_value   = '0;
    ring_occ               = '0;
    visit_site             = 0;
    sites_left             = 0;
    prev_full              = 1'b0;
    thr_after_empty        = PROB_EMPTY_RST;
    thr_after_full         = PROB_OCC_RST;
    mismatch_count         = 0;
    src_gaps_on            = 1'b1;
    sink_stalls_on         = 1'b1;
    hold_off_cycles        = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_threshold_extremes();
    test_backpressure();
    test_random_traffic();

    settle_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : ring_exclusion_process_sweep_tb
`default_nettype wire

// ===== ring_exclusion_process_sweep.f =====
hdl/rep_pkg.sv
hdl/rep_if.sv
hdl/rep_site_update.sv
hdl/ring_exclusion_process_sweep.sv
dv/ring_exclusion_process_sweep_tb.sv
